[sv/tcd_pkg.sv]
// Shared types, constants and codes for the Telepen character decoder.
package tcd_pkg;

    localparam int W_BITS     = 12;
    localparam int THR_W      = W_BITS + 1;
    localparam int SUM_W      = W_BITS + 3;
    localparam int NUM_W      = 4;
    localparam int DIVD_W     = W_BITS + 4;
    localparam int DIV_STEPS  = DIVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int BITS_W     = 10;
    localparam int BCNT_W     = 4;
    localparam int CHAR_BITS  = 8;
    localparam int CODE_W     = 7;
    localparam int MOD_VAL    = 127;

    typedef logic [W_BITS-1:0] t_width;
    typedef logic [THR_W-1:0]  t_thr;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [NUM_W-1:0]  t_num;
    typedef logic [DIVD_W-1:0] t_divd;
    typedef logic [BITS_W-1:0] t_bits;
    typedef logic [BCNT_W-1:0] t_bcnt;
    typedef logic [CODE_W-1:0] t_code;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PAIR  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TOO_WIDE,
        ST_BIT_OVF,
        ST_PARITY,
        ST_PARTIAL,
        ST_TOO_FEW,
        ST_CHECKSUM
    } t_status;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_PAIR,
        CMD_END
    } t_cmd_kind;

    // For a start command wa/wb carry the start thresholds.
    typedef struct packed {
        t_cmd_kind kind;
        t_width    wa;
        t_width    wb;
    } t_cmd;

    typedef struct packed {
        logic    kind;
        t_code   code;
        t_status status;
    } t_res;

    typedef struct packed {
        logic  start;
        t_divd dividend;
        t_num  divisor;
    } t_div_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_divd quo;
    } t_div_rsp;

endpackage

[sv/tcd_front.sv]
// Input side: two-entry command queue that classifies ops and drops unused codes.
module tcd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic [1:0]      i_op,
    input  tcd_pkg::t_width i_bar_width,
    input  tcd_pkg::t_width i_space_width,
    input  tcd_pkg::t_width i_start_bar_threshold,
    input  tcd_pkg::t_width i_start_space_threshold,
    output logic            o_cmd_valid,
    output tcd_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_pop
);

    tcd_pkg::t_cmd r_q [2];
    tcd_pkg::t_cmd n_q [2];
    logic          r_wr, n_wr;
    logic          r_rd, n_rd;
    logic [1:0]    r_cnt, n_cnt;

    tcd_pkg::t_cmd cls;
    logic          cls_ok;
    logic          enq;
    logic          deq;

    always_comb begin
        cls    = '0;
        cls_ok = 1'b0;
        unique case (i_op)
            tcd_pkg::OP_START: begin
                cls_ok   = 1'b1;
                cls.kind = tcd_pkg::CMD_START;
                cls.wa   = i_start_bar_threshold;
                cls.wb   = i_start_space_threshold;
            end
            tcd_pkg::OP_PAIR: begin
                cls_ok   = 1'b1;
                cls.kind = tcd_pkg::CMD_PAIR;
                cls.wa   = i_bar_width;
                cls.wb   = i_space_width;
            end
            tcd_pkg::OP_END: begin
                cls_ok   = 1'b1;
                cls.kind = tcd_pkg::CMD_END;
            end
            default: begin
                cls_ok = 1'b0;
            end
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign enq         = push && !full && cls_ok;
    assign deq         = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_q   = r_q;
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (enq) begin
            n_q[r_wr] = cls;
            n_wr      = ~r_wr;
        end
        if (deq) begin
            n_rd = ~r_rd;
        end
        n_cnt = r_cnt + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
    end

endmodule

[sv/tcd_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module tcd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcd_pkg::t_div_req i_req,
    output tcd_pkg::t_div_rsp o_rsp
);

    tcd_pkg::t_divd                  r_quo;
    tcd_pkg::t_num                   r_rem;
    tcd_pkg::t_num                   r_dvs;
    logic [tcd_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic                            r_busy;
    logic                            r_done;

    logic [tcd_pkg::NUM_W:0] rem_sh;
    logic [tcd_pkg::NUM_W:0] rem_sub;
    logic                    qbit;

    always_comb begin
        rem_sh  = {r_rem, r_quo[tcd_pkg::DIVD_W-1]};
        qbit    = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= tcd_pkg::DIV_CNT_W'(tcd_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - tcd_pkg::DIV_CNT_W'(1);
            if (r_cnt == tcd_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end

        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[tcd_pkg::DIVD_W-2:0], qbit};
            r_rem <= qbit ? rem_sub[tcd_pkg::NUM_W-1:0] : rem_sh[tcd_pkg::NUM_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

[sv/tcd_back.sv]
// Execution side: symbol state, bit assembly, threshold adaption and result queue.
module tcd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  tcd_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output tcd_pkg::t_div_req o_div_req,
    input  tcd_pkg::t_div_rsp i_div_rsp,
    output logic              o_empty,
    input  logic              i_pop,
    output tcd_pkg::t_res     o_res
);

    typedef enum logic [2:0] {
        S_WAIT,
        S_UPD,
        S_DIVA,
        S_DIVB,
        S_DIV2
    } t_state;

    t_state          r_state, n_state;
    logic            r_active, n_active;
    tcd_pkg::t_status r_fail, n_fail;
    tcd_pkg::t_thr   r_thr [2];
    tcd_pkg::t_thr   n_thr [2];
    tcd_pkg::t_bits  r_bits, n_bits;
    tcd_pkg::t_bcnt  r_bcnt, n_bcnt;
    logic            r_tog, n_tog;
    tcd_pkg::t_sum   r_sum [4];
    tcd_pkg::t_sum   n_sum [4];
    tcd_pkg::t_num   r_num [4];
    tcd_pkg::t_num   n_num [4];
    tcd_pkg::t_code  r_s127, n_s127;
    tcd_pkg::t_code  r_prev, n_prev;
    logic [1:0]      r_seen, n_seen;
    logic            r_side, n_side;
    tcd_pkg::t_width r_qa, n_qa;

    tcd_pkg::t_res   r_oq [2];
    tcd_pkg::t_res   n_oq [2];
    logic            r_oq_wr, n_oq_wr;
    logic            r_oq_rd, n_oq_rd;
    logic [1:0]      r_oq_cnt, n_oq_cnt;

    logic            oq_push;
    logic            oq_pop;
    tcd_pkg::t_res   push_res;

    // pair evaluation
    tcd_pkg::t_sum   lim_b, lim_s;
    logic            too_wide;
    logic            wb, ws;
    logic [2:0]      seq;
    tcd_pkg::t_bcnt  nbits;
    tcd_pkg::t_bits  pr_bits;
    tcd_pkg::t_bcnt  pr_cnt;
    logic [tcd_pkg::CODE_W:0] ck_sum;
    tcd_pkg::t_code  ck_exp;

    // update side selection
    tcd_pkg::t_sum   u_sw, u_sn;
    tcd_pkg::t_num   u_cw, u_cn;
    logic [tcd_pkg::DIVD_W:0] avg_sum;

    always_comb begin
        lim_b    = tcd_pkg::t_sum'(r_thr[0]) + tcd_pkg::t_sum'({r_thr[0], 1'b0});
        lim_s    = tcd_pkg::t_sum'(r_thr[1]) + tcd_pkg::t_sum'({r_thr[1], 1'b0});
        too_wide = (tcd_pkg::t_sum'(i_cmd.wa) > lim_b) || (tcd_pkg::t_sum'(i_cmd.wb) > lim_s);
        wb       = tcd_pkg::t_thr'(i_cmd.wa) > r_thr[0];
        ws       = tcd_pkg::t_thr'(i_cmd.wb) > r_thr[1];
        // seq holds the new bits, first received in bit 0
        case ({wb, ws})
            2'b00: begin
                seq   = 3'b001;
                nbits = tcd_pkg::t_bcnt'(1);
            end
            2'b01: begin
                seq   = r_tog ? 3'b001 : 3'b010;
                nbits = tcd_pkg::t_bcnt'(2);
            end
            2'b10: begin
                seq   = 3'b000;
                nbits = tcd_pkg::t_bcnt'(2);
            end
            default: begin
                seq   = 3'b010;
                nbits = tcd_pkg::t_bcnt'(3);
            end
        endcase
        pr_bits = r_bits | (tcd_pkg::t_bits'(seq) << r_bcnt);
        pr_cnt  = r_bcnt + nbits;

        ck_sum = {1'b0, r_s127} + {1'b0, r_prev};
        if (ck_sum >= (tcd_pkg::CODE_W+1)'(tcd_pkg::MOD_VAL)) begin
            ck_sum = ck_sum - (tcd_pkg::CODE_W+1)'(tcd_pkg::MOD_VAL);
        end
        ck_exp = (r_s127 == '0) ? '0 : tcd_pkg::t_code'(tcd_pkg::MOD_VAL) - r_s127;

        u_sw = r_side ? r_sum[1] : r_sum[0];
        u_cw = r_side ? r_num[1] : r_num[0];
        u_sn = r_side ? r_sum[3] : r_sum[2];
        u_cn = r_side ? r_num[3] : r_num[2];
        avg_sum = {1'b0, tcd_pkg::t_divd'(r_qa)} + {1'b0, i_div_rsp.quo};
    end

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_fail   = r_fail;
        n_thr    = r_thr;
        n_bits   = r_bits;
        n_bcnt   = r_bcnt;
        n_tog    = r_tog;
        n_sum    = r_sum;
        n_num    = r_num;
        n_s127   = r_s127;
        n_prev   = r_prev;
        n_seen   = r_seen;
        n_side   = r_side;
        n_qa     = r_qa;
        oq_push  = 1'b0;
        push_res = '0;
        o_cmd_pop = 1'b0;
        o_div_req = '0;

        unique case (r_state)
            S_WAIT: begin
                if (i_cmd_valid && (r_oq_cnt != 2'd2)) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        tcd_pkg::CMD_START: begin
                            n_active = 1'b1;
                            n_fail   = tcd_pkg::ST_OK;
                            n_thr[0] = tcd_pkg::t_thr'(i_cmd.wa);
                            n_thr[1] = tcd_pkg::t_thr'(i_cmd.wb);
                            n_bits   = '0;
                            n_bcnt   = '0;
                            n_tog    = 1'b0;
                            for (int k = 0; k < 4; k++) begin
                                n_sum[k] = '0;
                                n_num[k] = '0;
                            end
                            n_s127   = '0;
                            n_prev   = '0;
                            n_seen   = 2'd0;
                        end
                        tcd_pkg::CMD_PAIR: begin
                            if (r_active && (r_fail == tcd_pkg::ST_OK)) begin
                                if (too_wide) begin
                                    n_fail          = tcd_pkg::ST_TOO_WIDE;
                                    oq_push         = 1'b1;
                                    push_res.kind   = tcd_pkg::KIND_CHAR;
                                    push_res.status = tcd_pkg::ST_TOO_WIDE;
                                end else begin
                                    n_bits = pr_bits;
                                    n_bcnt = pr_cnt;
                                    if (!wb && ws) begin
                                        n_tog = ~r_tog;
                                    end
                                    if (wb) begin
                                        n_sum[0] = r_sum[0] + tcd_pkg::t_sum'(i_cmd.wa);
                                        n_num[0] = r_num[0] + tcd_pkg::t_num'(1);
                                    end else begin
                                        n_sum[2] = r_sum[2] + tcd_pkg::t_sum'(i_cmd.wa);
                                        n_num[2] = r_num[2] + tcd_pkg::t_num'(1);
                                    end
                                    if (ws) begin
                                        n_sum[1] = r_sum[1] + tcd_pkg::t_sum'(i_cmd.wb);
                                        n_num[1] = r_num[1] + tcd_pkg::t_num'(1);
                                    end else begin
                                        n_sum[3] = r_sum[3] + tcd_pkg::t_sum'(i_cmd.wb);
                                        n_num[3] = r_num[3] + tcd_pkg::t_num'(1);
                                    end
                                    if (pr_cnt > tcd_pkg::t_bcnt'(tcd_pkg::CHAR_BITS)) begin
                                        n_fail          = tcd_pkg::ST_BIT_OVF;
                                        oq_push         = 1'b1;
                                        push_res.kind   = tcd_pkg::KIND_CHAR;
                                        push_res.status = tcd_pkg::ST_BIT_OVF;
                                    end else if (pr_cnt == tcd_pkg::t_bcnt'(tcd_pkg::CHAR_BITS)) begin
                                        oq_push       = 1'b1;
                                        push_res.kind = tcd_pkg::KIND_CHAR;
                                        if (^pr_bits[tcd_pkg::CHAR_BITS-1:0]) begin
                                            n_fail          = tcd_pkg::ST_PARITY;
                                            push_res.status = tcd_pkg::ST_PARITY;
                                        end else begin
                                            push_res.status = tcd_pkg::ST_OK;
                                            push_res.code   = pr_bits[tcd_pkg::CODE_W-1:0];
                                            if (r_seen != 2'd0) begin
                                                n_s127 = ck_sum[tcd_pkg::CODE_W-1:0];
                                            end
                                            n_prev = pr_bits[tcd_pkg::CODE_W-1:0];
                                            if (r_seen != 2'd2) begin
                                                n_seen = r_seen + 2'd1;
                                            end
                                            // sums are cleared once the thresholds adapt
                                            n_bits  = '0;
                                            n_bcnt  = '0;
                                            n_tog   = 1'b0;
                                            n_side  = 1'b0;
                                            n_state = S_UPD;
                                        end
                                    end
                                end
                            end
                        end
                        tcd_pkg::CMD_END: begin
                            if (r_active) begin
                                n_active      = 1'b0;
                                oq_push       = 1'b1;
                                push_res.kind = tcd_pkg::KIND_END;
                                if (r_fail != tcd_pkg::ST_OK) begin
                                    push_res.status = r_fail;
                                end else if (r_bcnt != '0) begin
                                    push_res.status = tcd_pkg::ST_PARTIAL;
                                end else if (r_seen != 2'd2) begin
                                    push_res.status = tcd_pkg::ST_TOO_FEW;
                                end else if (ck_exp != r_prev) begin
                                    push_res.status = tcd_pkg::ST_CHECKSUM;
                                end else begin
                                    push_res.status = tcd_pkg::ST_OK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UPD: begin
                if ((u_cw != '0) && (u_cn != '0)) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = tcd_pkg::t_divd'(u_sw);
                    o_div_req.divisor  = u_cw;
                    n_state            = S_DIVA;
                end else if (u_cn != '0) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = tcd_pkg::t_divd'({u_sn, 1'b0});
                    o_div_req.divisor  = u_cn;
                    n_state            = S_DIV2;
                end else if (r_side) begin
                    for (int k = 0; k < 4; k++) begin
                        n_sum[k] = '0;
                        n_num[k] = '0;
                    end
                    n_state = S_WAIT;
                end else begin
                    n_side = 1'b1;
                end
            end
            S_DIVA: begin
                if (i_div_rsp.done) begin
                    n_qa               = i_div_rsp.quo[tcd_pkg::W_BITS-1:0];
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = tcd_pkg::t_divd'(u_sn);
                    o_div_req.divisor  = u_cn;
                    n_state            = S_DIVB;
                end
            end
            S_DIVB, S_DIV2: begin
                if (i_div_rsp.done) begin
                    if (r_state == S_DIVB) begin
                        n_thr[r_side] = avg_sum[tcd_pkg::THR_W:1];
                    end else begin
                        n_thr[r_side] = i_div_rsp.quo[tcd_pkg::THR_W-1:0];
                    end
                    if (r_side) begin
                        for (int k = 0; k < 4; k++) begin
                            n_sum[k] = '0;
                            n_num[k] = '0;
                        end
                        n_state = S_WAIT;
                    end else begin
                        n_side  = 1'b1;
                        n_state = S_UPD;
                    end
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    // result queue
    assign oq_pop  = i_pop && (r_oq_cnt != 2'd0);
    assign o_empty = (r_oq_cnt == 2'd0);
    assign o_res   = r_oq[r_oq_rd];

    always_comb begin
        n_oq    = r_oq;
        n_oq_wr = r_oq_wr;
        n_oq_rd = r_oq_rd;
        if (oq_push) begin
            n_oq[r_oq_wr] = push_res;
            n_oq_wr       = ~r_oq_wr;
        end
        if (oq_pop) begin
            n_oq_rd = ~r_oq_rd;
        end
        n_oq_cnt = r_oq_cnt + {1'b0, oq_push} - {1'b0, oq_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_WAIT;
            r_active <= 1'b0;
            r_fail   <= tcd_pkg::ST_OK;
            r_thr    <= '{default: '0};
            r_bits   <= '0;
            r_bcnt   <= '0;
            r_tog    <= 1'b0;
            r_sum    <= '{default: '0};
            r_num    <= '{default: '0};
            r_s127   <= '0;
            r_prev   <= '0;
            r_seen   <= 2'd0;
            r_side   <= 1'b0;
            r_oq_wr  <= 1'b0;
            r_oq_rd  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_fail   <= n_fail;
            r_thr    <= n_thr;
            r_bits   <= n_bits;
            r_bcnt   <= n_bcnt;
            r_tog    <= n_tog;
            r_sum    <= n_sum;
            r_num    <= n_num;
            r_s127   <= n_s127;
            r_prev   <= n_prev;
            r_seen   <= n_seen;
            r_side   <= n_side;
            r_oq_wr  <= n_oq_wr;
            r_oq_rd  <= n_oq_rd;
            r_oq_cnt <= n_oq_cnt;
        end
        r_qa <= n_qa;
        r_oq <= n_oq;
    end

    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_push |-> (r_oq_cnt != 2'd2))
        else $error("result queue written while full");

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> !i_div_rsp.busy)
        else $error("divider started while busy");

    // a failed character may leave eight or more bits behind
    a_bits_below_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WAIT) && (r_fail == tcd_pkg::ST_OK)) |->
        (r_bcnt < tcd_pkg::t_bcnt'(tcd_pkg::CHAR_BITS)))
        else $error("pending bit count reached a full character");

    a_char_starts_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (oq_push && (push_res.kind == tcd_pkg::KIND_CHAR) &&
         (push_res.status == tcd_pkg::ST_OK)) |=> (r_state == S_UPD))
        else $error("decoded character did not start threshold update");

endmodule

[sv/telepen_char_decoder_core.sv]
// Top level of the Telepen character decoder: command queue, executor, divider.
// An item is registered in the command queue and its result in the result queue.
// Throughput: one item per cycle unless the result queue is full or a pair completes
// a character, which holds the executor for the threshold update: up to four passes
// of the 16-step divider; the two-entry command queue takes up to two items meanwhile.
// Reset: synchronous active low; both queues empty, no symbol in progress.
module telepen_char_decoder_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 i_op,
    input  logic [tcd_pkg::W_BITS-1:0] i_bar_width,
    input  logic [tcd_pkg::W_BITS-1:0] i_space_width,
    input  logic [tcd_pkg::W_BITS-1:0] i_start_bar_threshold,
    input  logic [tcd_pkg::W_BITS-1:0] i_start_space_threshold,
    output logic                       empty,
    input  logic                       pop,
    output logic                       o_kind,
    output logic [6:0]                 o_char_code,
    output logic [2:0]                 o_status
);

    logic              cmd_valid;
    tcd_pkg::t_cmd     cmd;
    logic              cmd_pop;
    tcd_pkg::t_div_req div_req;
    tcd_pkg::t_div_rsp div_rsp;
    tcd_pkg::t_res     res;

    tcd_front u_front (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .push                    (push),
        .full                    (full),
        .i_op                    (i_op),
        .i_bar_width             (i_bar_width),
        .i_space_width           (i_space_width),
        .i_start_bar_threshold   (i_start_bar_threshold),
        .i_start_space_threshold (i_start_space_threshold),
        .o_cmd_valid             (cmd_valid),
        .o_cmd                   (cmd),
        .i_cmd_pop               (cmd_pop)
    );

    tcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    assign o_kind      = res.kind;
    assign o_char_code = res.code;
    assign o_status    = res.status;

endmodule

[tb/sv/tb_telepen_char_decoder_core.sv]
// Self-checking testbench for the Telepen character decoder core: predictor, scoreboard, stimulus.
module tb_telepen_char_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tcd_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES = 100;
    localparam int RANDOM_ITEMS = 1025;
    localparam int NUM_PHASES = 5;
    localparam int SEND_IDLE[NUM_PHASES] = '{0, 72, 0, 20, 0};
    localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 72, 20, 0};
    localparam int MAX_PRINTED = 100;

    typedef enum int {PAIR_NN, PAIR_NW, PAIR_WN, PAIR_WW} t_pair_class;

    class tcd_scoreboard;
        bit      active;
        t_status fail_code;
        int      thr[2];
        t_bits   char_bits;
        int      bit_count;
        bit      toggle;
        int      wsum[4];
        int      wcnt[4];
        int      sum127;
        t_code   prev_char;
        int      chars_seen;
        t_res    expected_q[$];
        int      errors;
        int      live_items;
        int      result_idx;

        function new();
            fail_code = ST_OK;
            clear_char();
        endfunction

        function void clear_char();
            char_bits = '0;
            bit_count = 0;
            toggle = 1'b0;
            foreach (wsum[i]) begin
                wsum[i] = 0;
                wcnt[i] = 0;
            end
        endfunction

        // pattern is shifted in MSB first; bit i of char_bits is the i-th bit received
        function void append_bits(int pattern, int n);
            int i;
            for (i = 0; i < n; i++) begin
                if (bit_count < BITS_W)
                    char_bits[bit_count] = 1'((pattern >> (n - 1 - i)) & 1);
                bit_count++;
            end
        endfunction

        function void add_result(logic kind, t_code code, t_status st);
            t_res r;
            r.kind = kind;
            r.code = code;
            r.status = st;
            expected_q.push_back(r);
        endfunction

        function void note_item(logic [1:0] op, t_width bw, t_width sw, t_width sbt, t_width sst);
            int      w[2];
            bit      wb, ws;
            int      i, slot, wn, nn;
            t_status st;
            w[0] = int'(bw);
            w[1] = int'(sw);
            if (op == OP_START) begin
                fail_code = ST_OK;
                clear_char();
                sum127 = 0;
                prev_char = '0;
                chars_seen = 0;
                active = 1'b1;
                thr[0] = int'(sbt);
                thr[1] = int'(sst);
                live_items++;
            end else if (op == OP_PAIR) begin
                if (!active || fail_code != ST_OK)
                    return;
                live_items++;
                if (w[0] > 3 * thr[0] || w[1] > 3 * thr[1]) begin
                    fail_code = ST_TOO_WIDE;
                    add_result(KIND_CHAR, '0, ST_TOO_WIDE);
                    return;
                end
                wb = w[0] > thr[0];
                ws = w[1] > thr[1];
                case ({wb, ws})
                    2'b00: append_bits(1, 1);
                    2'b01: begin
                        append_bits(toggle ? 2 : 1, 2);
                        toggle = !toggle;
                    end
                    2'b10: append_bits(0, 2);
                    default: append_bits(2, 3);
                endcase
                for (i = 0; i < 2; i++) begin
                    slot = (w[i] > thr[i]) ? i : i + 2;
                    wsum[slot] += w[i];
                    wcnt[slot]++;
                end
                if (bit_count < CHAR_BITS)
                    return;
                if (bit_count > CHAR_BITS) begin
                    fail_code = ST_BIT_OVF;
                    add_result(KIND_CHAR, '0, ST_BIT_OVF);
                    return;
                end
                if (^char_bits[7:0]) begin
                    fail_code = ST_PARITY;
                    add_result(KIND_CHAR, '0, ST_PARITY);
                    return;
                end
                for (i = 0; i < 2; i++) begin
                    wn = wcnt[i];
                    nn = wcnt[i + 2];
                    if (wn != 0 && nn != 0)
                        thr[i] = (wsum[i] / wn + wsum[i + 2] / nn) / 2;
                    else if (nn != 0)
                        thr[i] = (2 * wsum[i + 2]) / nn;
                end
                if (chars_seen != 0)
                    sum127 = (sum127 + prev_char) % MOD_VAL;
                prev_char = char_bits[6:0];
                if (chars_seen < 2)
                    chars_seen++;
                clear_char();
                add_result(KIND_CHAR, prev_char, ST_OK);
            end else if (op == OP_END) begin
                if (!active)
                    return;
                live_items++;
                if (fail_code != ST_OK)
                    st = fail_code;
                else if (bit_count != 0)
                    st = ST_PARTIAL;
                else if (chars_seen < 2)
                    st = ST_TOO_FEW;
                else if ((MOD_VAL - sum127) % MOD_VAL != prev_char)
                    st = ST_CHECKSUM;
                else
                    st = ST_OK;
                active = 1'b0;
                add_result(KIND_END, '0, st);
            end
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] MISMATCH result %0d: %s", $time, result_idx, msg);
            errors++;
        endtask

        task check_result(logic kind, logic [6:0] code, logic [2:0] status);
            t_res exp_r;
            result_idx++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected kind=%0d code=%0d status=%0d",
                                          kind, code, status));
                return;
            end
            exp_r = expected_q.pop_front();
            if (kind !== exp_r.kind)
                report_mismatch($sformatf("kind %0d, want %0d", kind, exp_r.kind));
            if (code !== exp_r.code)
                report_mismatch($sformatf("char_code %0d, want %0d", code, exp_r.code));
            if (status !== exp_r.status)
                report_mismatch($sformatf("status %0d, want %0d", status, exp_r.status));
        endtask

        task flush_check();
            t_res exp_r;
            while (expected_q.size() != 0) begin
                exp_r = expected_q.pop_front();
                report_mismatch($sformatf("missing kind=%0d code=%0d status=%0d",
                                          exp_r.kind, exp_r.code, exp_r.status));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_op;
    t_width      i_bar_width;
    t_width      i_space_width;
    t_width      i_start_bar_threshold;
    t_width      i_start_space_threshold;
    logic        empty;
    logic        pop;
    logic        o_kind;
    logic [6:0]  o_char_code;
    logic [2:0]  o_status;

    tcd_scoreboard sb;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            quiet_cycles = 0;
    t_pair_class   char_plan[$];

    telepen_char_decoder_core dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .push                    (push),
        .full                    (full),
        .i_op                    (i_op),
        .i_bar_width             (i_bar_width),
        .i_space_width           (i_space_width),
        .i_start_bar_threshold   (i_start_bar_threshold),
        .i_start_space_threshold (i_start_space_threshold),
        .empty                   (empty),
        .pop                     (pop),
        .o_kind                  (o_kind),
        .o_char_code             (o_char_code),
        .o_status                (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: check each transfer, random stalls, count cycles with no transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                sb.check_result(o_kind, o_char_code, o_status);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_item(logic [1:0] op, t_width bw, t_width sw, t_width sbt, t_width sst);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_op <= op;
        i_bar_width <= bw;
        i_space_width <= sw;
        i_start_bar_threshold <= sbt;
        i_start_space_threshold <= sst;
        do @(posedge i_clk); while (full);
        sb.note_item(op, bw, sw, sbt, sst);
    endtask

    // hold off the sender until every predicted result has been popped
    task automatic wait_results_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    function automatic t_width pick_width(int t, bit wide);
        int lo, hi;
        if (wide) begin
            lo = t + 1 + t / 5;
            hi = (2 * t > 4095) ? 4095 : 2 * t;
            if (lo > hi) begin
                lo = t + 1;
                hi = (3 * t > 4095) ? 4095 : 3 * t;
            end
            if (lo > hi)
                return 12'hfff;
        end else begin
            lo = t / 3;
            hi = t - t / 5;
            if (hi > 4095)
                hi = 4095;
            if (lo > hi)
                lo = hi;
        end
        return t_width'($urandom_range(hi, lo));
    endfunction

    task automatic send_pair(t_pair_class pc);
        t_width bw, sw;
        bw = pick_width(sb.thr[0], pc == PAIR_WN || pc == PAIR_WW);
        sw = pick_width(sb.thr[1], pc == PAIR_NW || pc == PAIR_WW);
        send_item(OP_PAIR, bw, sw, t_width'($urandom), t_width'($urandom));
    endtask

    // random walk over the pair classes that reproduce the eight bits; retried on a dead end
    function automatic bit plan_char(logic [7:0] v);
        int          pos, attempt;
        bit          tog;
        t_pair_class opts[$];
        t_pair_class pc;
        for (attempt = 0; attempt < 32; attempt++) begin
            char_plan.delete();
            pos = 0;
            tog = 1'b0;
            while (pos < CHAR_BITS) begin
                opts.delete();
                if (v[pos])
                    opts.push_back(PAIR_NN);
                if (pos < 7 && v[pos] == tog && v[pos + 1] != tog)
                    opts.push_back(PAIR_NW);
                if (pos < 7 && !v[pos] && !v[pos + 1])
                    opts.push_back(PAIR_WN);
                if (pos < 6 && !v[pos] && v[pos + 1] && !v[pos + 2])
                    opts.push_back(PAIR_WW);
                if (opts.size() == 0)
                    break;
                pc = opts[$urandom_range(opts.size() - 1)];
                char_plan.push_back(pc);
                case (pc)
                    PAIR_NN: pos += 1;
                    PAIR_NW: begin
                        pos += 2;
                        tog = !tog;
                    end
                    PAIR_WN: pos += 2;
                    default: pos += 3;
                endcase
            end
            if (pos == CHAR_BITS)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_noise();
        send_item(($urandom_range(3) == 0) ? OP_UNUSED : OP_PAIR, t_width'($urandom),
                  t_width'($urandom), t_width'($urandom), t_width'($urandom));
    endtask

    // one symbol: mostly well formed, sometimes with noise, cut characters or no end
    task automatic run_symbol();
        int          n_chars, k, i, n_send, s;
        t_code       c;
        t_width      bt, st;
        t_pair_class plan[$];
        if ($urandom_range(9) == 0) begin
            bt = t_width'($urandom_range(4095, 1));
            st = t_width'($urandom_range(4095, 1));
        end else begin
            bt = t_width'($urandom_range(300, 3));
            st = t_width'($urandom_range(300, 3));
        end
        if ($urandom_range(19) == 0)
            send_item(2'($urandom_range(3, 1)), t_width'($urandom), t_width'($urandom),
                      t_width'($urandom), t_width'($urandom));
        send_item(OP_START, t_width'($urandom), t_width'($urandom), bt, st);
        n_chars = $urandom_range(5, 1);
        for (k = 0; k < n_chars; k++) begin
            if ($urandom_range(99) < 4)
                send_noise();
            if (k == n_chars - 1 && $urandom_range(9) < 8) begin
                s = (sb.chars_seen != 0) ? (sb.sum127 + sb.prev_char) % MOD_VAL : 0;
                c = t_code'((MOD_VAL - s) % MOD_VAL);
            end else begin
                c = t_code'($urandom);
            end
            while (!plan_char({^c, c}))
                c = t_code'($urandom);
            plan = char_plan;
            n_send = plan.size();
            if ($urandom_range(49) == 0)
                n_send = $urandom_range(plan.size() - 1, 0);
            for (i = 0; i < n_send; i++) begin
                if ($urandom_range(59) == 0)
                    send_pair(t_pair_class'($urandom_range(3)));
                else
                    send_pair(plan[i]);
            end
        end
        if ($urandom_range(19) != 0)
            send_item(OP_END, t_width'($urandom), t_width'($urandom), t_width'($urandom),
                      t_width'($urandom));
    endtask

    initial begin
        int phase, target;
        sb = new();
        i_rst_n <= 1'b0;
        push <= 1'b0;
        pop <= 1'b0;
        i_op <= OP_START;
        i_bar_width <= '0;
        i_space_width <= '0;
        i_start_bar_threshold <= '0;
        i_start_space_threshold <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle decoder ignores everything but a start
        send_item(OP_UNUSED, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
        send_item(OP_PAIR, '0, '0, '0, '0);
        send_item(OP_END, '0, '0, '0, '0);
        // zero thresholds: only zero widths pass
        send_item(OP_START, '0, '0, '0, '0);
        send_item(OP_PAIR, '0, '0, '0, '0);
        send_item(OP_PAIR, '0, 12'd1, '0, '0);
        send_item(OP_PAIR, '0, '0, '0, '0);
        send_item(OP_END, '0, '0, '0, '0);
        // 01 followed by six ones: odd parity
        send_item(OP_START, 12'hfff, 12'hfff, 12'd2047, 12'd2047);
        send_item(OP_PAIR, '0, 12'hfff, '0, '0);
        repeat (3) begin
            send_item(OP_PAIR, '0, '0, '0, '0);
            send_item(OP_PAIR, 12'd2047, 12'd2047, '0, '0);
        end
        // 010 00 01 010 runs past eight bits
        send_item(OP_START, 12'hfff, 12'hfff, 12'd1, 12'd1);
        send_item(OP_PAIR, 12'd3, 12'd3, '0, '0);
        send_item(OP_PAIR, 12'd2, 12'd1, '0, '0);
        send_item(OP_PAIR, 12'd1, 12'd2, '0, '0);
        send_item(OP_PAIR, 12'd2, 12'd2, '0, '0);
        send_item(OP_END, '0, '0, '0, '0);
        // max thresholds and widths, end with one bit of a character received
        send_item(OP_START, '0, '0, 12'hfff, 12'hfff);
        send_item(OP_UNUSED, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
        send_item(OP_PAIR, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
        send_item(OP_END, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
        wait_results_drained();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            send_idle_pct = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            target = sb.live_items + RANDOM_ITEMS / NUM_PHASES;
            while (sb.live_items < target)
                run_symbol();
            wait_results_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.flush_check();
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

[sim.f]
sv/tcd_pkg.sv
sv/tcd_front.sv
sv/tcd_div.sv
sv/tcd_back.sv
sv/telepen_char_decoder_core.sv
tb/sv/tb_telepen_char_decoder_core.sv
